>>> rtl/olid_pkg.sv
package olid_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VAL_W    = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_READOUT   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SH_RD,
    S_SH_WR,
    S_RO_RD,
    S_RO_DATA
  } state_e;

endpackage

>>> rtl/olid_mem.sv
module olid_mem
  import olid_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [VAL_W-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [VAL_W-1:0]         rdata_o
);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ordered_list_insert_delete_core.sv
// channel   dir  tdata             tuser          tlast
// s_axis    in   [31:0] value      [1:0] cmd      -
// m_axis    out  [31:0] element    [1:0] status   last result of the command
//
// the list sits in a circular buffer with a single read and a single write port;
// the read port sets the pace. insert writes on acceptance, then sends a status beat.
// delete scans entries up to the match (all if none), moves each entry behind it one
// place forward, then sends a status beat; read out reads and sends each entry in turn.
// one shared unit maps a list position to a buffer address and one comparator
// checks entries; no command is taken until the last result beat has been loaded.
// a stalled result beat holds the sequencer; reset empties the list at once.
module ordered_list_insert_delete_core
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [VAL_W-1:0]    s_axis_tdata,   // [31:0] value
  input  logic [CMD_W-1:0]    s_axis_tuser,   // [1:0] cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [VAL_W-1:0]    m_axis_tdata,   // [31:0] element
  output logic [STATUS_W-1:0] m_axis_tuser,   // [1:0] status
  output logic                m_axis_tlast
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CAP_A = (AW+1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

  state_e state_q, state_d;

  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [VAL_W-1:0]    value_q, value_d;
  status_e             status_q, status_d;

  logic                m_valid_q, m_valid_d;
  logic [VAL_W-1:0]    m_data_q, m_data_d;
  logic [STATUS_W-1:0] m_user_q, m_user_d;
  logic                m_last_q, m_last_d;

  logic                accept;
  logic                out_free;
  logic [CW-1:0]       idx_inc;
  logic                full;
  logic [CW-1:0]       log_idx;
  logic [AW:0]         addr_sum;
  logic [AW-1:0]       phys_addr;
  logic [AW-1:0]       head_dec;
  logic                hit;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [VAL_W-1:0]    mem_wdata;
  logic [VAL_W-1:0]    mem_rdata;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign idx_inc  = idx_q + CW'(1);
  assign full     = (count_q == CAP_C);
  assign head_dec = (head_q == '0) ? LAST_A : head_q - AW'(1);
  assign hit      = (mem_rdata == value_q);

  // shared position to address unit
  always_comb begin
    case (state_q)
      S_IDLE:  log_idx = count_q;
      S_SH_RD: log_idx = idx_inc;
      default: log_idx = idx_q;
    endcase
  end

  assign addr_sum  = {1'b0, head_q} + (AW+1)'(log_idx);
  assign phys_addr = (addr_sum >= CAP_A) ? AW'(addr_sum - CAP_A) : addr_sum[AW-1:0];

  olid_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (phys_addr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (cmd_e'(s_axis_tuser))
            CMD_DELETE:  state_d = (count_q == '0) ? S_RESP : S_SCAN_RD;
            CMD_READOUT: state_d = (count_q == '0) ? S_RESP : S_RO_RD;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_RESP:     if (out_free) state_d = S_IDLE;
      S_SCAN_RD:  state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (hit) begin
          state_d = S_SH_RD;
        end else if (idx_inc == count_q) begin
          state_d = S_RESP;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SH_RD:    state_d = (idx_inc == count_q) ? S_RESP : S_SH_WR;
      S_SH_WR:    state_d = S_SH_RD;
      S_RO_RD:    state_d = S_RO_DATA;
      S_RO_DATA: begin
        if (out_free) begin
          state_d = (idx_inc == count_q) ? S_IDLE : S_RO_RD;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = phys_addr;
    mem_wdata = s_axis_tdata;
    count_d   = count_q;
    head_d    = head_q;
    idx_d     = idx_q;
    value_d   = value_q;
    status_d  = status_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          value_d  = s_axis_tdata;
          idx_d    = '0;
          status_d = ST_OK;
          case (cmd_e'(s_axis_tuser))
            CMD_INS_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                head_d    = head_dec;
                count_d   = count_q + CW'(1);
              end
            end
            CMD_INS_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            default: begin
              if (count_q == '0) status_d = ST_EMPTY;
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          m_user_d  = status_q;
          m_last_d  = 1'b1;
        end
      end
      S_SCAN_RD: mem_re = 1'b1;
      S_SCAN_CMP: begin
        if (!hit) begin
          idx_d = idx_inc;
          if (idx_inc == count_q) status_d = ST_NOTFOUND;
        end
      end
      S_SH_RD: begin
        if (idx_inc == count_q) begin
          count_d  = count_q - CW'(1);
          status_d = ST_OK;
        end else begin
          mem_re = 1'b1;
        end
      end
      S_SH_WR: begin
        // close the gap: entry behind moves one place forward
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_d     = idx_inc;
      end
      S_RO_RD: mem_re = 1'b1;
      S_RO_DATA: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = mem_rdata;
          m_user_d  = ST_OK;
          m_last_d  = (idx_inc == count_q);
          idx_d     = idx_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      head_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      head_q    <= head_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    value_q  <= value_d;
    status_q <= status_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("list count beyond capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LAST_A)
    else $error("head pointer out of range");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == CMD_INS_BACK) && !full
    |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the list");

  a_del_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (s_axis_tuser == CMD_DELETE) && (count_q == '0)
    |=> (state_q == S_RESP) && (status_q == ST_EMPTY))
    else $error("delete on empty list not reported");
`endif

endmodule
